// ===== hdl/nbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nbm_pkg;

  // CPU bus decode of the mapper registers.
  localparam logic [15:0] DECODE_MASK = 16'hE001;
  localparam logic [15:0] ADDR_SELECT = 16'h8000;
  localparam logic [15:0] ADDR_LOAD   = 16'h8001;

  // Bank select codes that bound the groups of the load write.
  localparam logic [2:0] SEL_CHR_PAIR_HI = 3'd1;
  localparam logic [2:0] SEL_CHR_LAST    = 3'd5;
  localparam logic [2:0] SEL_PRG_LOW     = 3'd6;

  // Configuration register indexes (address bit 2).
  localparam logic REG_PRG_SIZE = 1'b0;
  localparam logic REG_CHR_SIZE = 1'b1;
  localparam int   CFG_ADDR_W   = 3;

  localparam logic [7:0] PRG_SIZE_RESET = 8'd2;
  localparam logic [7:0] CHR_SIZE_RESET = 8'd1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_CPU_WRITE = 2'd0,
    ACT_CPU_READ  = 2'd1,
    ACT_PPU_READ  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PRG  = 2'd1,
    TGT_CHR  = 2'd2
  } target_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SELECT,
    OP_LOAD,
    OP_CPU_READ,
    OP_PPU_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] address;
    logic [7:0]  data;
  } bank_op_t;

  typedef struct packed {
    logic        start;
    logic [6:0]  value;
    logic [10:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] result;
  } mod_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/nbm_modred.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Iterative remainder: subtracts the divisor once per cycle until the value drops below it.
module nbm_modred (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire nbm_pkg::mod_req_t req,
  output nbm_pkg::mod_rsp_t      rsp
);

  logic        running;
  logic        done;
  logic [6:0]  rem;
  logic [10:0] div;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        rem     <= req.value;
        div     <= req.divisor;
      end else if (running) begin
        if ({4'b0000, rem} >= div) begin
          rem <= rem - div[6:0];
        end else begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = rem;

endmodule

`default_nettype wire

// ===== hdl/nbm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Accepts items and classifies them into the operation that the executer carries out.
module nbm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        action,
  input  wire logic [15:0]       address,
  input  wire logic [7:0]        data,
  input  wire logic [7:0]        prg_size_16k,
  input  wire logic [7:0]        chr_size_8k,
  input  wire logic              q_full,
  output logic                   push,
  output nbm_pkg::bank_op_t      op
);

  logic              f_valid;
  logic              accept;
  nbm_pkg::op_kind_t kind;

  assign in_stall = f_valid && q_full;
  assign push     = f_valid && !q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    kind = nbm_pkg::OP_NOP;
    unique case (action)
      nbm_pkg::ACT_CPU_WRITE: begin
        if ((address & nbm_pkg::DECODE_MASK) == nbm_pkg::ADDR_SELECT) begin
          kind = nbm_pkg::OP_SELECT;
        end else if ((address & nbm_pkg::DECODE_MASK) == nbm_pkg::ADDR_LOAD) begin
          kind = nbm_pkg::OP_LOAD;
        end
      end
      nbm_pkg::ACT_CPU_READ: begin
        if (address[15] && prg_size_16k != 8'd0) begin
          kind = nbm_pkg::OP_CPU_READ;
        end
      end
      nbm_pkg::ACT_PPU_READ: begin
        if (address[15:13] == 3'd0 && chr_size_8k != 8'd0) begin
          kind = nbm_pkg::OP_PPU_READ;
        end
      end
      default: kind = nbm_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      op.kind    <= kind;
      op.address <= address;
      op.data    <= data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nbm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Small first-in first-out queue of classified operations.
module nbm_queue #(
  parameter int DEPTH = nbm_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire nbm_pkg::bank_op_t push_op,
  output logic                   full,
  output logic                   valid,
  input  wire logic              pop,
  output nbm_pkg::bank_op_t      pop_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nbm_pkg::bank_op_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_op  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nbm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Executer: holds the bank registers, translates reads and runs bank loads
// through the iterative remainder unit.
module nbm_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire nbm_pkg::bank_op_t q_op,
  output logic                   pop,
  input  wire logic [7:0]        prg_size_16k,
  input  wire logic [7:0]        chr_size_8k,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             target,
  output logic [21:0]            rom_offset
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE_FIRST,
    S_REDUCE_SECOND
  } state_t;

  state_t            state;
  logic [2:0]        bank_select;
  logic [6:0]        chr_slots [8];
  logic [3:0]        prg_low;
  logic [3:0]        prg_high;
  logic [2:0]        load_sel;
  logic [6:0]        load_value;
  nbm_pkg::target_t  result_target;
  logic [21:0]       result_offset;

  nbm_pkg::mod_req_t mod_req;
  nbm_pkg::mod_rsp_t mod_rsp;

  logic [8:0]        prg_count;
  logic [10:0]       chr_div;
  logic [10:0]       prg_div;
  logic [8:0]        cpu_page;
  logic [21:0]       cpu_offset;
  logic [21:0]       ppu_offset;
  logic              sel_is_chr;
  logic              load_is_chr;

  nbm_modred u_modred (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  assign pop = (state == S_IDLE) && q_valid && (!out_valid || !out_stall);

  assign prg_count   = {prg_size_16k, 1'b0};
  assign chr_div     = {chr_size_8k, 3'b000};
  assign prg_div     = {2'b00, prg_size_16k, 1'b0};
  assign sel_is_chr  = (bank_select <= nbm_pkg::SEL_CHR_LAST);
  assign load_is_chr = (load_sel <= nbm_pkg::SEL_CHR_LAST);

  // The two top program slots are fixed to the last two 8KB pages.
  always_comb begin
    case (q_op.address[14:13])
      2'd0:    cpu_page = {5'b00000, prg_low};
      2'd1:    cpu_page = {5'b00000, prg_high};
      2'd2:    cpu_page = prg_count - 9'd2;
      default: cpu_page = prg_count - 9'd1;
    endcase
  end

  assign cpu_offset = {cpu_page, q_op.address[12:0]};
  assign ppu_offset = {5'b00000, chr_slots[q_op.address[12:10]], q_op.address[9:0]};

  // Remainder requests: the first value on a load, the second page of a CHR pair.
  always_comb begin
    mod_req.start   = 1'b0;
    mod_req.value   = load_value;
    mod_req.divisor = load_is_chr ? chr_div : prg_div;
    if (state == S_IDLE) begin
      if (sel_is_chr) begin
        mod_req.value   = {1'b0, q_op.data[5:0]};
        mod_req.divisor = chr_div;
        mod_req.start   = pop && (q_op.kind == nbm_pkg::OP_LOAD) && (chr_size_8k != 8'd0);
      end else begin
        mod_req.value   = {3'b000, q_op.data[3:0]};
        mod_req.divisor = prg_div;
        mod_req.start   = pop && (q_op.kind == nbm_pkg::OP_LOAD) && (prg_size_16k != 8'd0);
      end
    end else if (state == S_REDUCE_FIRST && mod_rsp.done && load_is_chr &&
                 load_sel <= nbm_pkg::SEL_CHR_PAIR_HI) begin
      mod_req.value = load_value + 7'd1;
      mod_req.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      bank_select <= 3'd0;
      prg_low     <= 4'd0;
      prg_high    <= 4'd1;
      for (int i = 0; i < 8; i++) begin
        chr_slots[i] <= 7'(i);
      end
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (q_op.kind == nbm_pkg::OP_SELECT) begin
              bank_select <= q_op.data[2:0];
            end
            load_sel   <= bank_select;
            load_value <= mod_req.value;
            if (mod_req.start) begin
              state <= S_REDUCE_FIRST;
            end
          end
        end
        S_REDUCE_FIRST: begin
          if (mod_rsp.done) begin
            if (load_is_chr) begin
              if (load_sel <= nbm_pkg::SEL_CHR_PAIR_HI) begin
                chr_slots[{load_sel[0], 2'b00} >> 1] <= mod_rsp.result;
                state <= S_REDUCE_SECOND;
              end else begin
                chr_slots[load_sel + 3'd2] <= mod_rsp.result;
                state <= S_IDLE;
              end
            end else begin
              if (load_sel == nbm_pkg::SEL_PRG_LOW) begin
                prg_low <= mod_rsp.result[3:0];
              end else begin
                prg_high <= mod_rsp.result[3:0];
              end
              state <= S_IDLE;
            end
          end
        end
        S_REDUCE_SECOND: begin
          if (mod_rsp.done) begin
            chr_slots[{1'b0, load_sel[0], 1'b1}] <= mod_rsp.result;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    if (pop) begin
      case (q_op.kind)
        nbm_pkg::OP_CPU_READ: begin
          result_target <= nbm_pkg::TGT_PRG;
          result_offset <= cpu_offset;
        end
        nbm_pkg::OP_PPU_READ: begin
          result_target <= nbm_pkg::TGT_CHR;
          result_offset <= ppu_offset;
        end
        default: begin
          result_target <= nbm_pkg::TGT_NONE;
          result_offset <= 22'd0;
        end
      endcase
    end
  end

  assign target     = result_target;
  assign rom_offset = result_offset;

endmodule

`default_nettype wire

// ===== hdl/nes_namco109_bank_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bank mapper for a Namco 109 style cartridge. Each item is either a CPU write
// (bank select at 0x8000, bank load at 0x8001 under the mask 0xE001) or a CPU or
// PPU read that is translated into a byte offset into program or character ROM;
// every item gives exactly one result item, in order. Items pass a front stage
// that classifies them, a short queue, and an executer with a registered result,
// so an item can be accepted while an earlier result still waits to be taken.
// Reads, bank-select writes and unmapped writes pass the front register, a queue
// entry and the result register, and stream at one item per cycle while the
// result is not stalled and no bank load holds the executer. A bank load occupies
// the executer while its value is reduced modulo the page count by an iterative
// subtract unit; the second page of a character page pair takes a second
// reduction after the first. A load that is ignored because its size is zero
// passes like a read. The ROM sizes are set through the APB-style port
// (program size at 0x0, character size at 0x4, in the low byte) and must only be
// written while the block is idle. A character size of zero means character RAM:
// character loads are then ignored and PPU reads give target 0. Pages already
// loaded are not reduced again when a size changes.
module nes_namco109_bank_mapper #(
  parameter int QUEUE_DEPTH = nbm_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     action,
  input  wire logic [15:0]                    address,
  input  wire logic [7:0]                     data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          target,
  output logic [21:0]                         rom_offset,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [nbm_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [7:0]        prg_size_16k;
  logic [7:0]        chr_size_8k;
  logic              cfg_write;
  logic              q_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  nbm_pkg::bank_op_t front_op;
  nbm_pkg::bank_op_t q_op;

  // Configuration registers. The port never waits.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_size_16k <= nbm_pkg::PRG_SIZE_RESET;
      chr_size_8k  <= nbm_pkg::CHR_SIZE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == nbm_pkg::REG_PRG_SIZE) begin
        prg_size_16k <= pwdata[7:0];
      end else begin
        chr_size_8k <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == nbm_pkg::REG_CHR_SIZE) ? {24'd0, chr_size_8k}
                                                      : {24'd0, prg_size_16k};

  // Front: accept and classify.
  nbm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .address      (address),
    .data         (data),
    .prg_size_16k (prg_size_16k),
    .chr_size_8k  (chr_size_8k),
    .q_full       (q_full),
    .push         (q_push),
    .op           (front_op)
  );

  // Queue between front and executer.
  nbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (front_op),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .pop_op  (q_op)
  );

  // Executer with bank registers and the result register.
  nbm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .pop          (q_pop),
    .prg_size_16k (prg_size_16k),
    .chr_size_8k  (chr_size_8k),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .target       (target),
    .rom_offset   (rom_offset)
  );

endmodule

`default_nettype wire

// ===== hdl/nbm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nbm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  target,
  input wire logic [21:0] rom_offset
);

  // No result is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(target) && $stable(rom_offset))
    else $error("stalled result changed");

  // Writes and unmapped reads carry a zero offset.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == nbm_pkg::TGT_NONE |-> rom_offset == 22'd0)
    else $error("nonzero offset with no target");

  // Character offsets stay within 128 pages of 1KB.
  a_chr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == nbm_pkg::TGT_CHR |-> rom_offset[21:17] == 5'd0)
    else $error("character offset out of range");

endmodule

bind nes_namco109_bank_mapper nbm_checker u_nbm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .target     (target),
  .rom_offset (rom_offset)
);

`default_nettype wire
